@@ sv/cfdc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfdc_pkg
// shared types, codes and defaults for the flow direction classifier
// ----------------------------------------------------------------------------
package cfdc_pkg;

    localparam int NUM_RANGES_DEF   = 4;
    localparam int NUM_EXCLUDES_DEF = 4;
    localparam int ADDR_W           = 64;
    localparam int PREFIX_W         = 8;
    localparam int IDX_W            = 2;

    typedef enum logic [1:0] {
        CMD_CLASSIFY    = 2'd0,
        CMD_WRITE_RANGE = 2'd1,
        CMD_WRITE_EXCL  = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_SRC  = 2'd1,
        DIR_DST  = 2'd2,
        DIR_RSVD = 2'd3
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the packet addresses
        logic sel_dst;   // test destination instead of source
        logic clr_excl;  // restart the exclusion scan
        logic step_excl; // advance the exclusion scan
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rng_live;  // current range valid and of the packet family
        logic rng_hit;   // current address inside current range
        logic excl_live; // current exclusion slot valid
        logic excl_hit;  // current address inside current exclusion
        logic excl_last; // current exclusion slot is the last one
        logic rng_last;  // current range slot is the last one
    } dp_sts_t;

    // true if address lies in base/plen of the given family
    function automatic logic in_prefix(input logic v6,
                                       input logic [ADDR_W-1:0] hi,
                                       input logic [ADDR_W-1:0] lo,
                                       input logic [ADDR_W-1:0] bhi,
                                       input logic [ADDR_W-1:0] blo,
                                       input logic [PREFIX_W-1:0] plen);
        logic [127:0] m;
        logic [127:0] diff;
        logic [7:0]   p;
        begin
            if (!v6)
            begin
                p = (plen > 8'd32) ? 8'd32 : plen;
                m = '0;
                for (int b = 0; b < 32; b++)
                    m[b] = (32 - b) <= int'(p);
                diff = {96'd0, lo[31:0] ^ blo[31:0]};
            end
            else
            begin
                p = (plen > 8'd128) ? 8'd128 : plen;
                for (int b = 0; b < 128; b++)
                    m[b] = (128 - b) <= int'(p);
                diff = {hi ^ bhi, lo ^ blo};
            end
            in_prefix = (diff & m) == '0;
        end
    endfunction

endpackage

@@ sv/cfdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfdc_ctrl
// sequencer walking ranges and exclusions for one classify beat
// ----------------------------------------------------------------------------
module cfdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output cfdc_pkg::dp_cmd_t cmd,
    input  cfdc_pkg::dp_sts_t sts,
    output logic              rng_step,
    output logic              done,
    output cfdc_pkg::mode_t   result,
    input  logic              out_free
);
    import cfdc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRC   = 5'b00010,
        S_DST   = 5'b00100,
        S_EXCL  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   dst_reg, dst_next;
    mode_t  mode_reg, mode_next;

    always_comb
    begin
        state_next = state_reg;
        dst_next   = dst_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        rng_step   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SRC;
                end
            end
            S_SRC:
            begin
                cmd.clr_excl = 1'b1;
                if (sts.rng_live && sts.rng_hit)
                begin
                    dst_next   = 1'b0;
                    state_next = S_EXCL;
                end
                else
                    state_next = S_DST;
            end
            S_DST:
            begin
                cmd.sel_dst  = 1'b1;
                cmd.clr_excl = 1'b1;
                if (sts.rng_live && sts.rng_hit)
                begin
                    dst_next   = 1'b1;
                    state_next = S_EXCL;
                end
                else if (sts.rng_last)
                begin
                    mode_next  = DIR_NONE;
                    state_next = S_DONE;
                end
                else
                begin
                    rng_step   = 1'b1;
                    state_next = S_SRC;
                end
            end
            S_EXCL:
            begin
                cmd.sel_dst   = dst_reg;
                cmd.step_excl = 1'b1;
                if (sts.excl_live && sts.excl_hit)
                begin
                    mode_next  = dst_reg ? DIR_SRC : DIR_DST;
                    state_next = S_DONE;
                end
                else if (!sts.excl_live || sts.excl_last)
                begin
                    mode_next  = dst_reg ? DIR_DST : DIR_SRC;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dst_reg   <= 1'b0;
            mode_reg  <= DIR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            dst_reg   <= dst_next;
            mode_reg  <= mode_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = (state_reg == S_DONE) && out_free;
    assign result = mode_reg;

endmodule

@@ sv/cfdc_dp.sv @@
// ----------------------------------------------------------------------------
// cfdc_dp
// rule tables, packet registers and the prefix comparators
// ----------------------------------------------------------------------------
module cfdc_dp #(
    parameter int NUM_RANGES   = cfdc_pkg::NUM_RANGES_DEF,
    parameter int NUM_EXCLUDES = cfdc_pkg::NUM_EXCLUDES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_range,
    input  logic                          wr_excl,
    input  logic                          is_v6,
    input  logic [cfdc_pkg::ADDR_W-1:0]   src_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   src_lo,
    input  logic [cfdc_pkg::ADDR_W-1:0]   dst_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   dst_lo,
    input  logic [cfdc_pkg::IDX_W-1:0]    net_index,
    input  logic [cfdc_pkg::IDX_W-1:0]    excl_index,
    input  logic [cfdc_pkg::ADDR_W-1:0]   rule_addr_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   rule_addr_lo,
    input  logic [cfdc_pkg::PREFIX_W-1:0] rule_prefix,
    input  logic                          rule_valid,
    input  cfdc_pkg::dp_cmd_t             cmd,
    input  logic                          rng_step,
    output cfdc_pkg::dp_sts_t             sts
);
    import cfdc_pkg::*;

    localparam int RI_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int EI_W = (NUM_EXCLUDES > 1) ? $clog2(NUM_EXCLUDES) : 1;
    localparam int NX   = NUM_RANGES * NUM_EXCLUDES;
    localparam int XI_W = (NX > 1) ? $clog2(NX) : 1;

    logic [NUM_RANGES-1:0] rv_reg;
    logic [NUM_RANGES-1:0] r6_reg;
    logic [ADDR_W-1:0]     rhi_reg [NUM_RANGES];
    logic [ADDR_W-1:0]     rlo_reg [NUM_RANGES];
    logic [PREFIX_W-1:0]   rpl_reg [NUM_RANGES];
    logic [NX-1:0]         xv_reg;
    logic [ADDR_W-1:0]     xhi_reg [NX];
    logic [ADDR_W-1:0]     xlo_reg [NX];
    logic [PREFIX_W-1:0]   xpl_reg [NX];

    logic              v6_reg;
    logic [ADDR_W-1:0] shi_reg, slo_reg, dhi_reg, dlo_reg;
    logic [RI_W-1:0]   ri_reg;
    logic [EI_W-1:0]   ei_reg;

    logic              ni_ok, ei_ok;
    logic [RI_W-1:0]   ni;
    logic [EI_W-1:0]   ei;
    logic [ADDR_W-1:0] ahi, alo;
    logic [XI_W-1:0]   k;
    logic [XI_W-1:0]   wk;

    assign ni    = RI_W'(net_index);
    assign ei    = EI_W'(excl_index);
    assign ni_ok = 32'(net_index) < NUM_RANGES;
    assign ei_ok = 32'(excl_index) < NUM_EXCLUDES;
    // flat exclusion slot being written
    assign wk    = XI_W'(ni) * XI_W'(NUM_EXCLUDES) + XI_W'(ei);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
            r6_reg <= '0;
            xv_reg <= '0;
            ri_reg <= '0;
            ei_reg <= '0;
        end
        else
        begin
            if (wr_range && ni_ok)
            begin
                rv_reg[ni] <= rule_valid;
                r6_reg[ni] <= is_v6;
            end
            if (wr_excl && ni_ok && ei_ok)
                xv_reg[wk] <= rule_valid;
            if (cmd.load)
                ri_reg <= '0;
            else if (rng_step)
                ri_reg <= ri_reg + 1'b1;
            if (cmd.clr_excl)
                ei_reg <= '0;
            else if (cmd.step_excl)
                ei_reg <= ei_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_range && ni_ok)
        begin
            rhi_reg[ni] <= rule_addr_hi;
            rlo_reg[ni] <= rule_addr_lo;
            rpl_reg[ni] <= rule_prefix;
        end
        if (wr_excl && ni_ok && ei_ok)
        begin
            xhi_reg[wk] <= rule_addr_hi;
            xlo_reg[wk] <= rule_addr_lo;
            xpl_reg[wk] <= rule_prefix;
        end
        if (cmd.load)
        begin
            v6_reg  <= is_v6;
            shi_reg <= src_hi;
            slo_reg <= src_lo;
            dhi_reg <= dst_hi;
            dlo_reg <= dst_lo;
        end
    end

    assign ahi = cmd.sel_dst ? dhi_reg : shi_reg;
    assign alo = cmd.sel_dst ? dlo_reg : slo_reg;
    assign k   = XI_W'(ri_reg) * XI_W'(NUM_EXCLUDES) + XI_W'(ei_reg);

    always_comb
    begin
        sts.rng_live  = rv_reg[ri_reg] && (r6_reg[ri_reg] == v6_reg);
        sts.rng_hit   = in_prefix(v6_reg, ahi, alo, rhi_reg[ri_reg],
                                  rlo_reg[ri_reg], rpl_reg[ri_reg]);
        sts.excl_live = xv_reg[k];
        sts.excl_hit  = in_prefix(v6_reg, ahi, alo, xhi_reg[k], xlo_reg[k],
                                  xpl_reg[k]);
        sts.excl_last = 32'(ei_reg) == NUM_EXCLUDES - 1;
        sts.rng_last  = 32'(ri_reg) == NUM_RANGES - 1;
    end

endmodule

@@ sv/cidr_flow_direction_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// cidr_flow_direction_classifier_unit
// prefix match with per-range exclusions, giving flow aggregation direction
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | command, is_v6, addresses, rule fields
//  out     | out_valid | out_stall | mode
//
// write beats finish in the cycle they are accepted
// a classify beat walks the ranges in slot order, testing each range against
// source then destination; on the first range hit it scans that range's
// exclusion slots in order until one hits, one is invalid or the last is scanned
// the result register holds mode while out_valid and out_stall are high; in_stall is
// high for as long as a classify beat is in flight
// reset clears all valid bits and the sequencer; no clearing pass
// ----------------------------------------------------------------------------
module cidr_flow_direction_classifier_unit #(
    parameter int NUM_RANGES   = cfdc_pkg::NUM_RANGES_DEF,
    parameter int NUM_EXCLUDES = cfdc_pkg::NUM_EXCLUDES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic                          is_v6,
    input  logic [cfdc_pkg::ADDR_W-1:0]   src_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   src_lo,
    input  logic [cfdc_pkg::ADDR_W-1:0]   dst_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   dst_lo,
    input  logic [cfdc_pkg::IDX_W-1:0]    net_index,
    input  logic [cfdc_pkg::IDX_W-1:0]    excl_index,
    input  logic [cfdc_pkg::ADDR_W-1:0]   rule_addr_hi,
    input  logic [cfdc_pkg::ADDR_W-1:0]   rule_addr_lo,
    input  logic [cfdc_pkg::PREFIX_W-1:0] rule_prefix,
    input  logic                          rule_valid,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    mode
);
    import cfdc_pkg::*;

    logic      acc, busy, done, rng_step, out_free;
    dp_cmd_t   cmd;
    dp_sts_t   sts;
    mode_t     result;
    logic      ov_reg;
    logic [1:0] mode_reg;

    // a beat is taken only when no classify is in flight
    assign in_stall = busy;
    assign acc      = in_valid && !busy;
    // result register is free when empty or being drained
    assign out_free = !ov_reg || !out_stall;

    cfdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc && command == CMD_CLASSIFY),
        .busy     (busy),
        .cmd      (cmd),
        .sts      (sts),
        .rng_step (rng_step),
        .done     (done),
        .result   (result),
        .out_free (out_free)
    );

    cfdc_dp #(
        .NUM_RANGES   (NUM_RANGES),
        .NUM_EXCLUDES (NUM_EXCLUDES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_range     (acc && command == CMD_WRITE_RANGE),
        .wr_excl      (acc && command == CMD_WRITE_EXCL),
        .is_v6        (is_v6),
        .src_hi       (src_hi),
        .src_lo       (src_lo),
        .dst_hi       (dst_hi),
        .dst_lo       (dst_lo),
        .net_index    (net_index),
        .excl_index   (excl_index),
        .rule_addr_hi (rule_addr_hi),
        .rule_addr_lo (rule_addr_lo),
        .rule_prefix  (rule_prefix),
        .rule_valid   (rule_valid),
        .cmd          (cmd),
        .rng_step     (rng_step),
        .sts          (sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            mode_reg <= result;
    end

    assign out_valid = ov_reg;
    assign mode      = mode_reg;

endmodule

@@ sv/cfdc_checker.sv @@
// ----------------------------------------------------------------------------
// cfdc_checker
// port level checks on the classifier
// ----------------------------------------------------------------------------
module cfdc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] mode
);
    import cfdc_pkg::*;

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mode))
        else $error("stalled result changed");

    // mode never carries the reserved code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mode != DIR_RSVD)
        else $error("reserved mode");

    // a classify beat stalls the input the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_CLASSIFY |=> in_stall)
        else $error("classify not in flight");

    // write beats do not occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command != CMD_CLASSIFY |=> !in_stall)
        else $error("write held the input");

endmodule

bind cidr_flow_direction_classifier_unit cfdc_checker u_cfdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mode      (mode)
);
